// File: hdl/avi_pkg.sv
// shared widths, reset values and register indexes of the agent velocity integrator
// no dependencies
`default_nettype none
package avi_pkg;

  // configuration port
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] REG_FORCE_LIMIT  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_SPEED_LIMIT  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_WORLD_WIDTH  = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_WORLD_HEIGHT = 2'd3;

  localparam logic [15:0] FORCE_LIMIT_RST  = 16'd410;
  localparam logic [15:0] SPEED_LIMIT_RST  = 16'd8192;
  localparam logic [11:0] WORLD_WIDTH_RST  = 12'd1200;
  localparam logic [11:0] WORLD_HEIGHT_RST = 12'd800;

  // stream widths
  localparam int InDataW  = 136;
  localparam int OutDataW = 88;

  // heading is limited to one in Q1.14
  localparam logic [14:0] HEAD_ONE = 15'd16384;

  // at or below this speed the heading is forced to zero
  localparam logic [21:0] STOP_SPEED = 22'd4;

endpackage
`default_nettype wire

// File: hdl/avi_isqrt_pipe.sv
// pipelined integer square root, one result bit per stage, floor(sqrt(x))
// no package dependencies; stall enable shared with the surrounding pipeline
`default_nettype none
module avi_isqrt_pipe #(
  parameter int IN_W  = 42,
  parameter int TAG_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   in_radicand,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [IN_W/2-1:0]      out_root,
  output logic [TAG_W-1:0]       out_tag
);

  localparam int R_W = IN_W / 2;

  logic [IN_W-1:0]  rem  [0:R_W];
  logic [IN_W-1:0]  root [0:R_W];
  logic [TAG_W-1:0] tag  [0:R_W];
  logic             vld  [0:R_W];

  assign rem[0]  = in_radicand;
  assign root[0] = '0;
  assign tag[0]  = in_tag;
  assign vld[0]  = in_valid;

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    localparam logic [IN_W-1:0] Bit = IN_W'(1) << (2 * (R_W - 1 - i));
    logic [IN_W:0] trial;
    logic          fits;

    // try setting this root bit
    assign trial = {1'b0, root[i]} + {1'b0, Bit};
    assign fits  = {1'b0, rem[i]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[i+1] <= tag[i];
        if (fits) begin
          rem[i+1]  <= rem[i] - trial[IN_W-1:0];
          root[i+1] <= (root[i] >> 1) + Bit;
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= root[i] >> 1;
        end
      end
    end
  end

  assign out_valid = vld[R_W];
  assign out_root  = root[R_W][R_W-1:0];
  assign out_tag   = tag[R_W];

endmodule
`default_nettype wire

// File: hdl/avi_div_pipe.sv
// two-lane pipelined restoring divider, one quotient bit per stage
// no package dependencies; quotient must fit in Q_W bits
`default_nettype none
module avi_div_pipe #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 21,
  parameter int Q_W   = 21,
  parameter int TAG_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num_a,
  input  wire logic [DEN_W-1:0]  in_den_a,
  input  wire logic [NUM_W-1:0]  in_num_b,
  input  wire logic [DEN_W-1:0]  in_den_b,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo_a,
  output logic [NUM_W-1:0]       out_rem_a,
  output logic [Q_W-1:0]         out_quo_b,
  output logic [NUM_W-1:0]       out_rem_b,
  output logic [TAG_W-1:0]       out_tag
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_a [0:Q_W];
  logic [NUM_W-1:0] rem_b [0:Q_W];
  logic [DEN_W-1:0] den_a [0:Q_W];
  logic [DEN_W-1:0] den_b [0:Q_W];
  logic [Q_W-1:0]   quo_a [0:Q_W];
  logic [Q_W-1:0]   quo_b [0:Q_W];
  logic [TAG_W-1:0] tag   [0:Q_W];
  logic             vld   [0:Q_W];

  assign rem_a[0] = in_num_a;
  assign rem_b[0] = in_num_b;
  assign den_a[0] = in_den_a;
  assign den_b[0] = in_den_b;
  assign quo_a[0] = '0;
  assign quo_b[0] = '0;
  assign tag[0]   = in_tag;
  assign vld[0]   = in_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic [CW-1:0] sub_a;
    logic [CW-1:0] sub_b;
    logic          ge_a;
    logic          ge_b;

    // compare against the divisor shifted to this quotient bit
    assign sub_a = CW'(den_a[i]) << K;
    assign sub_b = CW'(den_b[i]) << K;
    assign ge_a  = CW'(rem_a[i]) >= sub_a;
    assign ge_b  = CW'(rem_b[i]) >= sub_b;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[i+1]   <= tag[i];
        den_a[i+1] <= den_a[i];
        den_b[i+1] <= den_b[i];
        rem_a[i+1] <= ge_a ? NUM_W'(CW'(rem_a[i]) - sub_a) : rem_a[i];
        rem_b[i+1] <= ge_b ? NUM_W'(CW'(rem_b[i]) - sub_b) : rem_b[i];
        quo_a[i+1] <= quo_a[i] | (ge_a ? (Q_W'(1) << K) : '0);
        quo_b[i+1] <= quo_b[i] | (ge_b ? (Q_W'(1) << K) : '0);
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo_a = quo_a[Q_W];
  assign out_rem_a = rem_a[Q_W];
  assign out_quo_b = quo_b[Q_W];
  assign out_rem_b = rem_b[Q_W];
  assign out_tag   = tag[Q_W];

endmodule
`default_nettype wire

// File: hdl/agent_velocity_integrator_unit.sv
// top level of the agent velocity integrator: stream ports, config registers, datapath glue
// depends on avi_pkg, avi_isqrt_pipe and avi_div_pipe
`default_nettype none
// Advances one agent by one Euler step per item: the acceleration is limited to
// force_limit, velocity is heading times speed plus acceleration, limited to
// speed_limit, the new heading is velocity over speed (zero at 4 LSB or less),
// and the position moves by the velocity and wraps into the world. One item is
// taken every clock cycle while the output side keeps up; the pipeline holds
// the chain of two 21/22-stage square roots, two 21-stage dividers and the
// 15-stage heading and wrap dividers, one bit per stage.
// A stall on the output holds the whole pipeline. Configuration writes take
// effect at once and are meant to be made while no item is in flight.
module agent_velocity_integrator_unit
  import avi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // slave side: pos_x, pos_y, dir_x, dir_y, speed_in, accel_x, accel_y, 6 zero pad bits
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [InDataW-1:0]  s_tdata,
  // master side: new_pos_x, new_pos_y, new_dir_x, new_dir_y, new_speed
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OutDataW-1:0]      m_tdata,
  // configuration write port
  input  wire logic                cfg_wr_en,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  typedef struct packed {
    logic [19:0]        px;
    logic [19:0]        py;
    logic signed [20:0] ax;
    logic signed [20:0] ay;
    logic signed [31:0] pdx;
    logic signed [31:0] pdy;
    logic               over;
  } acc_tag_t;

  typedef struct packed {
    logic [19:0]        px;
    logic [19:0]        py;
    logic signed [21:0] vx;
    logic signed [21:0] vy;
    logic               over;
  } vel_tag_t;

  typedef struct packed {
    logic        vxneg;
    logic        vyneg;
    logic        stop;
    logic [15:0] speed;
  } head_tag_t;

  typedef struct packed {
    logic negx;
    logic negy;
  } wrap_tag_t;

  // configuration registers
  logic [15:0] force_limit;
  logic [15:0] speed_limit;
  logic [11:0] world_width;
  logic [11:0] world_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_limit  <= FORCE_LIMIT_RST;
      speed_limit  <= SPEED_LIMIT_RST;
      world_width  <= WORLD_WIDTH_RST;
      world_height <= WORLD_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FORCE_LIMIT:  force_limit  <= cfg_wdata;
        REG_SPEED_LIMIT:  speed_limit  <= cfg_wdata;
        REG_WORLD_WIDTH:  world_width  <= cfg_wdata[11:0];
        REG_WORLD_HEIGHT: world_height <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // wrap spans in Q13.8, zero size means 4096 pixels
  logic [20:0] span_x;
  logic [20:0] span_y;
  assign span_x = (world_width == '0)  ? 21'h100000 : {1'b0, world_width, 8'd0};
  assign span_y = (world_height == '0) ? 21'h100000 : {1'b0, world_height, 8'd0};

  // whole pipeline advances together
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input unpack
  logic [19:0]        in_px;
  logic [19:0]        in_py;
  logic signed [15:0] in_dx;
  logic signed [15:0] in_dy;
  logic [15:0]        in_spd;
  logic signed [20:0] in_ax;
  logic signed [20:0] in_ay;
  logic [20:0]        in_amx;
  logic [20:0]        in_amy;

  assign in_px  = s_tdata[19:0];
  assign in_py  = s_tdata[39:20];
  assign in_dx  = s_tdata[55:40];
  assign in_dy  = s_tdata[71:56];
  assign in_spd = s_tdata[87:72];
  assign in_ax  = s_tdata[108:88];
  assign in_ay  = s_tdata[129:109];
  assign in_amx = in_ax[20] ? 21'(-in_ax) : 21'(in_ax);
  assign in_amy = in_ay[20] ? 21'(-in_ay) : 21'(in_ay);

  // stage 1: squares of acceleration and heading times speed
  logic               s1_vld;
  logic [19:0]        s1_px;
  logic [19:0]        s1_py;
  logic signed [20:0] s1_ax;
  logic signed [20:0] s1_ay;
  logic [40:0]        s1_ax2;
  logic [40:0]        s1_ay2;
  logic [31:0]        s1_flsq;
  logic signed [31:0] s1_pdx;
  logic signed [31:0] s1_pdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px   <= in_px;
      s1_py   <= in_py;
      s1_ax   <= in_ax;
      s1_ay   <= in_ay;
      s1_ax2  <= in_amx * in_amx;
      s1_ay2  <= in_amy * in_amy;
      s1_flsq <= force_limit * force_limit;
      s1_pdx  <= 32'(in_dx * $signed({1'b0, in_spd}));
      s1_pdy  <= 32'(in_dy * $signed({1'b0, in_spd}));
    end
  end

  // stage 2: squared length and limit check
  logic        s2_vld;
  logic [41:0] s2_a2;
  acc_tag_t    s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a2       <= 42'(s1_ax2) + 42'(s1_ay2);
      s2_tag.px   <= s1_px;
      s2_tag.py   <= s1_py;
      s2_tag.ax   <= s1_ax;
      s2_tag.ay   <= s1_ay;
      s2_tag.pdx  <= s1_pdx;
      s2_tag.pdy  <= s1_pdy;
      s2_tag.over <= (42'(s1_ax2) + 42'(s1_ay2)) > 42'(s1_flsq);
    end
  end

  // acceleration length
  logic                   sq1_vld;
  logic [20:0]            sq1_len;
  logic [$bits(acc_tag_t)-1:0] sq1_tag_bits;
  acc_tag_t               sq1_tag;

  avi_isqrt_pipe #(
    .IN_W  (42),
    .TAG_W ($bits(acc_tag_t))
  ) u_sqrt_acc (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s2_vld),
    .in_radicand (s2_a2),
    .in_tag      (s2_tag),
    .out_valid   (sq1_vld),
    .out_root    (sq1_len),
    .out_tag     (sq1_tag_bits)
  );
  assign sq1_tag = acc_tag_t'(sq1_tag_bits);

  // stage 3: scale numerators
  logic        s3_vld;
  logic [36:0] s3_numx;
  logic [36:0] s3_numy;
  logic [20:0] s3_len;
  acc_tag_t    s3_tag;
  logic [20:0] sq1_amx;
  logic [20:0] sq1_amy;

  assign sq1_amx = sq1_tag.ax[20] ? 21'(-sq1_tag.ax) : 21'(sq1_tag.ax);
  assign sq1_amy = sq1_tag.ay[20] ? 21'(-sq1_tag.ay) : 21'(sq1_tag.ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_numx <= sq1_amx * force_limit;
      s3_numy <= sq1_amy * force_limit;
      s3_len  <= sq1_len;
      s3_tag  <= sq1_tag;
    end
  end

  // acceleration scaling
  logic                   d1_vld;
  logic [20:0]            d1_qx;
  logic [20:0]            d1_qy;
  logic [$bits(acc_tag_t)-1:0] d1_tag_bits;
  acc_tag_t               d1_tag;

  avi_div_pipe #(
    .NUM_W (37),
    .DEN_W (21),
    .Q_W   (21),
    .TAG_W ($bits(acc_tag_t))
  ) u_div_acc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_vld),
    .in_num_a  (s3_numx),
    .in_den_a  (s3_len),
    .in_num_b  (s3_numy),
    .in_den_b  (s3_len),
    .in_tag    (s3_tag),
    .out_valid (d1_vld),
    .out_quo_a (d1_qx),
    .out_rem_a (),
    .out_quo_b (d1_qy),
    .out_rem_b (),
    .out_tag   (d1_tag_bits)
  );
  assign d1_tag = acc_tag_t'(d1_tag_bits);

  // stage 4: limited acceleration plus rounded heading times speed
  logic signed [21:0] lim_ax;
  logic signed [21:0] lim_ay;
  logic [32:0]        pm_x;
  logic [32:0]        pm_y;
  logic [17:0]        pr_x;
  logic [17:0]        pr_y;
  logic signed [21:0] hs_x;
  logic signed [21:0] hs_y;

  always_comb begin
    if (d1_tag.over) begin
      lim_ax = d1_tag.ax[20] ? -$signed({1'b0, d1_qx}) : $signed({1'b0, d1_qx});
      lim_ay = d1_tag.ay[20] ? -$signed({1'b0, d1_qy}) : $signed({1'b0, d1_qy});
    end else begin
      lim_ax = 22'(d1_tag.ax);
      lim_ay = 22'(d1_tag.ay);
    end
  end

  assign pm_x = d1_tag.pdx[31] ? 33'(-34'(d1_tag.pdx)) : 33'(d1_tag.pdx);
  assign pm_y = d1_tag.pdy[31] ? 33'(-34'(d1_tag.pdy)) : 33'(d1_tag.pdy);
  assign pr_x = 18'((pm_x + 33'd8192) >> 14);
  assign pr_y = 18'((pm_y + 33'd8192) >> 14);
  assign hs_x = d1_tag.pdx[31] ? -$signed({4'd0, pr_x}) : $signed({4'd0, pr_x});
  assign hs_y = d1_tag.pdy[31] ? -$signed({4'd0, pr_y}) : $signed({4'd0, pr_y});

  logic               s4_vld;
  logic [19:0]        s4_px;
  logic [19:0]        s4_py;
  logic signed [21:0] s4_vx;
  logic signed [21:0] s4_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_px <= d1_tag.px;
      s4_py <= d1_tag.py;
      s4_vx <= hs_x + lim_ax;
      s4_vy <= hs_y + lim_ay;
    end
  end

  // stage 5: squares of velocity
  logic [20:0] s4_vmx;
  logic [20:0] s4_vmy;
  assign s4_vmx = s4_vx[21] ? 21'(-s4_vx) : 21'(s4_vx);
  assign s4_vmy = s4_vy[21] ? 21'(-s4_vy) : 21'(s4_vy);

  logic               s5_vld;
  logic [19:0]        s5_px;
  logic [19:0]        s5_py;
  logic signed [21:0] s5_vx;
  logic signed [21:0] s5_vy;
  logic [41:0]        s5_vx2;
  logic [41:0]        s5_vy2;
  logic [31:0]        s5_slsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_vx   <= s4_vx;
      s5_vy   <= s4_vy;
      s5_vx2  <= s4_vmx * s4_vmx;
      s5_vy2  <= s4_vmy * s4_vmy;
      s5_slsq <= speed_limit * speed_limit;
    end
  end

  // stage 6: squared speed and limit check
  logic        s6_vld;
  logic [43:0] s6_v2;
  vel_tag_t    s6_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_v2       <= 44'(s5_vx2) + 44'(s5_vy2);
      s6_tag.px   <= s5_px;
      s6_tag.py   <= s5_py;
      s6_tag.vx   <= s5_vx;
      s6_tag.vy   <= s5_vy;
      s6_tag.over <= (44'(s5_vx2) + 44'(s5_vy2)) > 44'(s5_slsq);
    end
  end

  // speed
  logic                   sq2_vld;
  logic [21:0]            sq2_len;
  logic [$bits(vel_tag_t)-1:0] sq2_tag_bits;
  vel_tag_t               sq2_tag;

  avi_isqrt_pipe #(
    .IN_W  (44),
    .TAG_W ($bits(vel_tag_t))
  ) u_sqrt_vel (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s6_vld),
    .in_radicand (s6_v2),
    .in_tag      (s6_tag),
    .out_valid   (sq2_vld),
    .out_root    (sq2_len),
    .out_tag     (sq2_tag_bits)
  );
  assign sq2_tag = vel_tag_t'(sq2_tag_bits);

  // stage 7: velocity scale numerators
  logic [20:0] sq2_vmx;
  logic [20:0] sq2_vmy;
  assign sq2_vmx = sq2_tag.vx[21] ? 21'(-sq2_tag.vx) : 21'(sq2_tag.vx);
  assign sq2_vmy = sq2_tag.vy[21] ? 21'(-sq2_tag.vy) : 21'(sq2_tag.vy);

  logic        s7_vld;
  logic [36:0] s7_numx;
  logic [36:0] s7_numy;
  logic [21:0] s7_len;
  vel_tag_t    s7_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= sq2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_numx <= sq2_vmx * speed_limit;
      s7_numy <= sq2_vmy * speed_limit;
      s7_len  <= sq2_len;
      s7_tag  <= sq2_tag;
    end
  end

  // velocity scaling
  logic                   d2_vld;
  logic [20:0]            d2_qx;
  logic [20:0]            d2_qy;
  logic [$bits(vel_tag_t)-1:0] d2_tag_bits;
  vel_tag_t               d2_tag;
  logic [21:0]            d2_len;

  avi_div_pipe #(
    .NUM_W (37),
    .DEN_W (22),
    .Q_W   (21),
    .TAG_W ($bits(vel_tag_t))
  ) u_div_vel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_vld),
    .in_num_a  (s7_numx),
    .in_den_a  (s7_len),
    .in_num_b  (s7_numy),
    .in_den_b  (s7_len),
    .in_tag    (s7_tag),
    .out_valid (d2_vld),
    .out_quo_a (d2_qx),
    .out_rem_a (),
    .out_quo_b (d2_qy),
    .out_rem_b (),
    .out_tag   (d2_tag_bits)
  );
  assign d2_tag = vel_tag_t'(d2_tag_bits);

  // the speed root travels beside the divider
  logic [21:0] len_dly [0:21];
  assign len_dly[0] = s7_len;
  for (genvar i = 0; i < 21; i++) begin : g_len_dly
    always_ff @(posedge clk) begin
      if (en) begin
        len_dly[i+1] <= len_dly[i];
      end
    end
  end
  assign d2_len = len_dly[21];

  // stage 8: final velocity and speed
  logic               s8_vld;
  logic [19:0]        s8_px;
  logic [19:0]        s8_py;
  logic signed [21:0] s8_vx;
  logic signed [21:0] s8_vy;
  logic [21:0]        s8_spd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_px <= d2_tag.px;
      s8_py <= d2_tag.py;
      if (d2_tag.over) begin
        s8_vx  <= d2_tag.vx[21] ? -$signed({1'b0, d2_qx}) : $signed({1'b0, d2_qx});
        s8_vy  <= d2_tag.vy[21] ? -$signed({1'b0, d2_qy}) : $signed({1'b0, d2_qy});
        s8_spd <= 22'(speed_limit);
      end else begin
        s8_vx  <= d2_tag.vx;
        s8_vy  <= d2_tag.vy;
        s8_spd <= d2_len;
      end
    end
  end

  // stage 9: heading numerators and unwrapped positions
  logic [20:0]        s8_vmx;
  logic [20:0]        s8_vmy;
  logic [17:0]        dm_x;
  logic [17:0]        dm_y;
  logic signed [22:0] q_x;
  logic signed [22:0] q_y;

  assign s8_vmx = s8_vx[21] ? 21'(-s8_vx) : 21'(s8_vx);
  assign s8_vmy = s8_vy[21] ? 21'(-s8_vy) : 21'(s8_vy);
  assign dm_x   = 18'((22'(s8_vmx) + 22'd8) >> 4);
  assign dm_y   = 18'((22'(s8_vmy) + 22'd8) >> 4);

  always_comb begin
    q_x = $signed({3'd0, s8_px}) + $signed({2'd0, span_x});
    q_y = $signed({3'd0, s8_py}) + $signed({2'd0, span_y});
    if (s8_vx[21]) begin
      q_x = q_x - $signed({5'd0, dm_x});
    end else begin
      q_x = q_x + $signed({5'd0, dm_x});
    end
    if (s8_vy[21]) begin
      q_y = q_y - $signed({5'd0, dm_y});
    end else begin
      q_y = q_y + $signed({5'd0, dm_y});
    end
  end

  logic        s9_vld;
  logic [35:0] s9_hnx;
  logic [35:0] s9_hny;
  logic [21:0] s9_spd;
  head_tag_t   s9_htag;
  wrap_tag_t   s9_wtag;
  logic [21:0] s9_qmx;
  logic [21:0] s9_qmy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else if (en) begin
      s9_vld <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_hnx        <= {1'b0, s8_vmx, 14'd0} + 36'(s8_spd >> 1);
      s9_hny        <= {1'b0, s8_vmy, 14'd0} + 36'(s8_spd >> 1);
      s9_spd        <= s8_spd;
      s9_htag.vxneg <= s8_vx[21];
      s9_htag.vyneg <= s8_vy[21];
      s9_htag.stop  <= s8_spd <= STOP_SPEED;
      s9_htag.speed <= s8_spd[15:0];
      s9_wtag.negx  <= q_x[22];
      s9_wtag.negy  <= q_y[22];
      s9_qmx        <= q_x[22] ? 22'(-q_x) : 22'(q_x);
      s9_qmy        <= q_y[22] ? 22'(-q_y) : 22'(q_y);
    end
  end

  // heading division
  logic                    dh_vld;
  logic [14:0]             dh_qx;
  logic [14:0]             dh_qy;
  logic [$bits(head_tag_t)-1:0] dh_tag_bits;
  head_tag_t               dh_tag;

  avi_div_pipe #(
    .NUM_W (36),
    .DEN_W (22),
    .Q_W   (15),
    .TAG_W ($bits(head_tag_t))
  ) u_div_head (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s9_vld),
    .in_num_a  (s9_hnx),
    .in_den_a  (s9_spd),
    .in_num_b  (s9_hny),
    .in_den_b  (s9_spd),
    .in_tag    (s9_htag),
    .out_valid (dh_vld),
    .out_quo_a (dh_qx),
    .out_rem_a (),
    .out_quo_b (dh_qy),
    .out_rem_b (),
    .out_tag   (dh_tag_bits)
  );
  assign dh_tag = head_tag_t'(dh_tag_bits);

  // position modulo, runs alongside the heading division
  logic [21:0]                  dw_rx;
  logic [21:0]                  dw_ry;
  logic [$bits(wrap_tag_t)-1:0] dw_tag_bits;
  wrap_tag_t                    dw_tag;

  avi_div_pipe #(
    .NUM_W (22),
    .DEN_W (21),
    .Q_W   (15),
    .TAG_W ($bits(wrap_tag_t))
  ) u_div_wrap (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s9_vld),
    .in_num_a  (s9_qmx),
    .in_den_a  (span_x),
    .in_num_b  (s9_qmy),
    .in_den_b  (span_y),
    .in_tag    (s9_wtag),
    .out_valid (),
    .out_quo_a (),
    .out_rem_a (dw_rx),
    .out_quo_b (),
    .out_rem_b (dw_ry),
    .out_tag   (dw_tag_bits)
  );
  assign dw_tag = wrap_tag_t'(dw_tag_bits);

  // final stage: heading sign and saturation, non-negative wrap
  logic [14:0] hm_x;
  logic [14:0] hm_y;
  logic [15:0] h_x;
  logic [15:0] h_y;
  logic [20:0] w_x;
  logic [20:0] w_y;

  assign hm_x = (dh_qx > HEAD_ONE) ? HEAD_ONE : dh_qx;
  assign hm_y = (dh_qy > HEAD_ONE) ? HEAD_ONE : dh_qy;
  assign h_x  = dh_tag.stop ? 16'd0 : (dh_tag.vxneg ? 16'(-{1'b0, hm_x}) : {1'b0, hm_x});
  assign h_y  = dh_tag.stop ? 16'd0 : (dh_tag.vyneg ? 16'(-{1'b0, hm_y}) : {1'b0, hm_y});
  assign w_x  = (dw_tag.negx && dw_rx != '0) ? span_x - dw_rx[20:0] : dw_rx[20:0];
  assign w_y  = (dw_tag.negy && dw_ry != '0) ? span_y - dw_ry[20:0] : dw_ry[20:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {dh_tag.speed, h_y, h_x, w_y[19:0], w_x[19:0]};
    end
  end

endmodule
`default_nettype wire

// File: bench/agent_velocity_integrator_unit_tb.sv
// testbench of the agent velocity integrator: random and directed agent items,
// a bit-exact step predictor and an in-order scoreboard of expected results
// depends on avi_pkg and agent_velocity_integrator_unit
`default_nettype none

typedef struct packed {
  logic [15:0] speed;
  logic [15:0] dir_y;
  logic [15:0] dir_x;
  logic [19:0] pos_y;
  logic [19:0] pos_x;
} step_result_t;

class step_scoreboard;
  step_result_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // note the expected result of an accepted item
  function void note_item(step_result_t r);
    pending = {pending, r};
  endfunction

  // compare a result with the oldest expectation
  function void check_result(step_result_t got);
    step_result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.pos_x !== want.pos_x) begin
      $error("new_pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
      errors++;
    end
    if (got.pos_y !== want.pos_y) begin
      $error("new_pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
      errors++;
    end
    if (got.dir_x !== want.dir_x) begin
      $error("new_dir_x expected %0d actual %0d", $signed(want.dir_x), $signed(got.dir_x));
      errors++;
    end
    if (got.dir_y !== want.dir_y) begin
      $error("new_dir_y expected %0d actual %0d", $signed(want.dir_y), $signed(got.dir_y));
      errors++;
    end
    if (got.speed !== want.speed) begin
      $error("out_speed expected %0d actual %0d", want.speed, got.speed);
      errors++;
    end
  endfunction
endclass

module agent_velocity_integrator_unit_tb;
  import avi_pkg::*;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  longint force_lim, speed_lim, world_w, world_h;

  step_scoreboard board;
  int idle_cycles;
  bit stall_free;

  agent_velocity_integrator_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint abs_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // divide by 2^s, rounding half away from zero
  function automatic longint round_shift(longint v, int s);
    longint m;
    m = (abs_of(v) + (64'sd1 << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  // scale a vector component by num/den, truncated toward zero
  function automatic longint scale_toward_zero(longint v, longint num, longint den);
    longint m;
    m = (abs_of(v) * num) / den;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint unit_component(longint v, longint s);
    longint m;
    m = (abs_of(v) * 16384 + s / 2) / s;
    if (m > 16384) m = 16384;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint wrap_pos(longint p, longint d, longint size);
    longint span, r;
    span = (size == 0 ? 4096 : size) << 8;
    r = (p + d + span) % span;
    if (r < 0) r += span;
    return r;
  endfunction

  // one Euler step of an agent
  function automatic step_result_t integrate_step(logic [InDataW-1:0] d);
    step_result_t r;
    longint px, py, dx, dy, spd, ax, ay, a2, v2, len, vx, vy, s, hx, hy;
    px = d[19:0];
    py = d[39:20];
    dx = $signed(d[55:40]);
    dy = $signed(d[71:56]);
    spd = d[87:72];
    ax = $signed(d[108:88]);
    ay = $signed(d[129:109]);
    hx = 0;
    hy = 0;
    a2 = ax * ax + ay * ay;
    if (a2 > force_lim * force_lim) begin
      len = int_sqrt(a2);
      ax = scale_toward_zero(ax, force_lim, len);
      ay = scale_toward_zero(ay, force_lim, len);
    end
    vx = round_shift(dx * spd, 14) + ax;
    vy = round_shift(dy * spd, 14) + ay;
    v2 = vx * vx + vy * vy;
    if (v2 > speed_lim * speed_lim) begin
      len = int_sqrt(v2);
      vx = scale_toward_zero(vx, speed_lim, len);
      vy = scale_toward_zero(vy, speed_lim, len);
      s = speed_lim;
    end else begin
      s = int_sqrt(v2);
    end
    if (s > 4) begin
      hx = unit_component(vx, s);
      hy = unit_component(vy, s);
    end
    r.pos_x = 20'(wrap_pos(px, round_shift(vx, 4), world_w));
    r.pos_y = 20'(wrap_pos(py, round_shift(vy, 4), world_h));
    r.dir_x = 16'(hx);
    r.dir_y = 16'(hy);
    r.speed = 16'(s);
    return r;
  endfunction

  function automatic logic [InDataW-1:0] pack_item(longint px, longint py, longint dx,
      longint dy, longint spd, longint ax, longint ay);
    logic [InDataW-1:0] d;
    d = '0;
    d[19:0] = 20'(px);
    d[39:20] = 20'(py);
    d[55:40] = 16'(dx);
    d[71:56] = 16'(dy);
    d[87:72] = 16'(spd);
    d[108:88] = 21'(ax);
    d[129:109] = 21'(ay);
    return d;
  endfunction

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FORCE_LIMIT: force_lim = val;
      REG_SPEED_LIMIT: speed_lim = val;
      REG_WORLD_WIDTH: world_w = val[11:0];
      default: world_h = val[11:0];
    endcase
  endtask

  // drive one item and hold it until taken; valid stays high for back-to-back items
  task automatic send_item(logic [InDataW-1:0] d);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    board.note_item(integrate_step(d));
  endtask

  task automatic send_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // random item, usually physically plausible, sometimes raw bits
  task automatic send_random();
    logic [InDataW-1:0] d;
    longint ang;
    d = InDataW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    d[InDataW-1:130] = '0;
    if ($urandom_range(0, 4) != 0) begin
      ang = $urandom_range(0, 16384);
      d = pack_item($urandom_range(0, 1048575), $urandom_range(0, 1048575),
          ($urandom_range(0, 1) ? -ang : ang),
          ($urandom_range(0, 1) ? -1 : 1) * int_sqrt(16384 * 16384 - ang * ang),
          $urandom_range(0, 12000), longint'($urandom_range(0, 1200)) - 600,
          longint'($urandom_range(0, 1200)) - 600);
    end
    send_item(d);
    send_gap();
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(pack_item(0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(1048575, 1048575, 16384, 16384, 65535, 1048575, 1048575));
    send_item(pack_item(0, 0, -16384, -16384, 65535, -1048576, -1048576));
    send_item(pack_item(1000, 2000, 16384, 0, 3, 0, 0));
    send_item(pack_item(1000, 2000, 16384, 0, 4, 0, 1));
    send_item(pack_item(0, 0, -16384, 0, 4096, 0, 0));
    send_item(pack_item(307199, 204799, 16384, 16384, 8192, 0, 0));
    send_item(pack_item(5, 5, 0, -16384, 4096, 300, -300));
    send_item(pack_item(524288, 524288, -32768, 32767, 40000, -1, 1));
    send_item(pack_item(100, 100, 11585, -11585, 6000, 409, -2));
    s_tvalid <= 1'b0;
  endtask

  // receiver stalls on random cycles, with a stall-free stretch during one register phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 9) > 2);
    end
  end

  // check accepted results
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(step_result_t'(m_tdata));
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    stall_free = 1'b0;
    force_lim = FORCE_LIMIT_RST;
    speed_lim = SPEED_LIMIT_RST;
    world_w = WORLD_WIDTH_RST;
    world_h = WORLD_HEIGHT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    drain();
    // phases of register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_FORCE_LIMIT, 0);
          write_reg(REG_SPEED_LIMIT, 0);
          write_reg(REG_WORLD_WIDTH, 0);
          write_reg(REG_WORLD_HEIGHT, 1);
        end
        1: begin
          write_reg(REG_FORCE_LIMIT, 16'hFFFF);
          write_reg(REG_SPEED_LIMIT, 16'hFFFF);
          write_reg(REG_WORLD_WIDTH, 4095);
          write_reg(REG_WORLD_HEIGHT, 0);
        end
        2: begin
          write_reg(REG_FORCE_LIMIT, 410);
          write_reg(REG_SPEED_LIMIT, 8192);
          write_reg(REG_WORLD_WIDTH, 1);
          write_reg(REG_WORLD_HEIGHT, 4095);
        end
        default: begin
          write_reg(REG_FORCE_LIMIT, 16'($urandom_range(0, 2000)));
          write_reg(REG_SPEED_LIMIT, 16'($urandom_range(0, 16000)));
          write_reg(REG_WORLD_WIDTH, 16'($urandom_range(1, 4095)));
          write_reg(REG_WORLD_HEIGHT, 16'($urandom_range(1, 4095)));
        end
      endcase
      stall_free = (ph == 2);
      if (ph == 0) begin
        send_item(pack_item(1048575, 1048575, 16384, -16384, 65535, 1048575, -1048576));
        send_item(pack_item(0, 0, 0, 0, 0, 500, 500));
      end
      repeat (100) send_random();
      s_tvalid <= 1'b0;
      drain();
      stall_free = 1'b0;
    end
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
hdl/avi_pkg.sv
hdl/avi_isqrt_pipe.sv
hdl/avi_div_pipe.sv
hdl/agent_velocity_integrator_unit.sv
bench/agent_velocity_integrator_unit_tb.sv
